// ===== rtl/ilf_pkg.sv =====
// Shared types and constants for the IMAP literal line framer.
package ilf_pkg;

  // Byte codes the framer looks for
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned LEN_W = 31;
  localparam int unsigned ACC_W = 32;

  // Literal size accumulator saturates at 2^31
  localparam logic [ACC_W-1:0] SIZE_SAT = 32'h8000_0000;
  localparam logic [LEN_W-1:0] MAX_LIT_RESET = 31'h7FFF_FFFF;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_BRACE  = 2'd1;
  localparam logic [1:0] ERR_BAD_DIGIT = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG   = 2'd3;

  // One framed result
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_payload;
    logic             literal_begins;
    logic [LEN_W-1:0] literal_length;
    logic             response_done;
    logic [1:0]       error_code;
  } result_t;

endpackage

// ===== rtl/ilf_if.sv =====
// Channel interfaces: received bytes, framed results and the size-limit write.
interface ilf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ilf_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        is_payload;
  logic                        literal_begins;
  logic [ilf_pkg::LEN_W-1:0]   literal_length;
  logic                        response_done;
  logic [1:0]                  error_code;
  modport source (output valid, output out_byte, output is_payload, output literal_begins,
                  output literal_length, output response_done, output error_code,
                  input ready);
  modport sink (input valid, input out_byte, input is_payload, input literal_begins,
                input literal_length, input response_done, input error_code,
                output ready);
endinterface

interface ilf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ilf_pkg::LEN_W-1:0] max_literal_size;
  modport source (output valid, output max_literal_size, input ready);
  modport sink (input valid, input max_literal_size, output ready);
endinterface

// ===== rtl/ilf_skid.sv =====
// Output register with a skid stage so input ready does not depend on output ready.
module ilf_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  ilf_pkg::result_t s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output ilf_pkg::result_t m_data
);

  logic             main_v_r;
  logic             skid_v_r;
  ilf_pkg::result_t main_r;
  ilf_pkg::result_t skid_r;
  logic             s_fire;

  assign s_ready = !skid_v_r;
  assign s_fire  = s_valid && s_ready;
  assign m_valid = main_v_r;
  assign m_data  = main_r;

  // Control: main slot refills from skid first, else from the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || m_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= s_fire;
      end
    end else if (s_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!main_v_r || m_ready) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else begin
        main_r <= s_data;
      end
    end else if (s_fire) begin
      skid_r <= s_data;
    end
  end

endmodule

// ===== rtl/imap_literal_line_framer.sv =====
// IMAP literal line framer: sorts received server bytes into response lines and literals.
// Takes one received byte per clock unless the skid stage is full, and returns one result per
// byte, in order, registered in the output register or in the skid stage. All framing state
// (two-byte window, brace and digit tracking, literal byte counter) updates in the cycle a
// byte is accepted, so bytes stream back to back; a skid stage on the output keeps input
// ready registered and lets the block keep accepting while one result waits. A line that
// ends in '}' CR LF with a valid decimal count between the last '{' and the '}' announces a
// literal; that many following bytes are marked as payload. Any other CR LF completes the
// response. A malformed announcement reports an error code on its LF and drops the line.
// max_literal_size must be written only while the block is idle.
module imap_literal_line_framer (
  input logic      clk,
  input logic      rst_n,
  ilf_in_if.sink   in_ch,
  ilf_out_if.source out_ch,
  ilf_cfg_if.sink  cfg_ch
);

  localparam int unsigned LW = ilf_pkg::LEN_W;
  localparam int unsigned AW = ilf_pkg::ACC_W;

  logic [LW-1:0] max_lit_r;

  logic          in_literal_r, in_literal_nxt;
  logic [LW-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]    recent0_r, recent0_nxt;
  logic [7:0]    recent1_r, recent1_nxt;
  logic          brace_seen_r, brace_seen_nxt;
  logic          digits_valid_r, digits_valid_nxt;
  logic          run_open_r, run_open_nxt;
  logic [AW-1:0] size_acc_r, size_acc_nxt;

  logic             in_fire;
  logic             skid_ready;
  ilf_pkg::result_t res;
  ilf_pkg::result_t out_data;
  logic [7:0]       b;
  logic [LW-1:0]    left_dec;
  logic [AW+3:0]    acc_x10;
  logic             fold_digit;

  assign b           = in_ch.rx_byte;
  assign in_ch.ready = skid_ready;
  assign in_fire     = in_ch.valid && skid_ready;
  assign cfg_ch.ready = 1'b1;

  // Size limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lit_r <= ilf_pkg::MAX_LIT_RESET;
    end else if (cfg_ch.valid) begin
      max_lit_r <= cfg_ch.max_literal_size;
    end
  end

  // Decimal step on the byte leaving the window
  assign fold_digit = (recent1_r >= ilf_pkg::CH_ZERO) && (recent1_r <= ilf_pkg::CH_NINE);
  assign acc_x10 = {1'b0, size_acc_r, 3'b000} + {3'b000, size_acc_r, 1'b0}
                 + {32'd0, recent1_r[3:0]};
  assign left_dec = (bytes_left_r != '0) ? bytes_left_r - LW'(1) : bytes_left_r;

  // Framing logic for one byte
  always_comb begin
    in_literal_nxt   = in_literal_r;
    bytes_left_nxt   = bytes_left_r;
    recent0_nxt      = recent0_r;
    recent1_nxt      = recent1_r;
    brace_seen_nxt   = brace_seen_r;
    digits_valid_nxt = digits_valid_r;
    run_open_nxt     = run_open_r;
    size_acc_nxt     = size_acc_r;

    res.out_byte       = b;
    res.is_payload     = 1'b0;
    res.literal_begins = 1'b0;
    res.literal_length = '0;
    res.response_done  = 1'b0;
    res.error_code     = ilf_pkg::ERR_NONE;

    if (in_literal_r) begin
      // payload byte
      res.is_payload = 1'b1;
      bytes_left_nxt = left_dec;
      if (left_dec == '0) begin
        in_literal_nxt = 1'b0;
        recent0_nxt    = '0;
        recent1_nxt    = '0;
      end
    end else if (b == ilf_pkg::CH_LF && recent0_r == ilf_pkg::CH_CR) begin
      // end of line
      if (recent1_r == ilf_pkg::CH_CLOSE) begin
        priority if (!brace_seen_r) begin
          res.error_code = ilf_pkg::ERR_NO_BRACE;
        end else if (!digits_valid_r) begin
          res.error_code = ilf_pkg::ERR_BAD_DIGIT;
        end else if (size_acc_r > {1'b0, max_lit_r}) begin
          res.error_code = ilf_pkg::ERR_TOO_BIG;
        end else begin
          res.literal_begins = 1'b1;
          res.literal_length = size_acc_r[LW-1:0];
          bytes_left_nxt     = size_acc_r[LW-1:0];
          in_literal_nxt     = (size_acc_r[LW-1:0] != '0);
        end
      end else begin
        res.response_done = 1'b1;
      end
      recent0_nxt      = '0;
      recent1_nxt      = '0;
      brace_seen_nxt   = 1'b0;
      digits_valid_nxt = 1'b0;
      run_open_nxt     = 1'b0;
      size_acc_nxt     = '0;
    end else begin
      // line text: fold the oldest window byte, then shift
      if (recent1_r == ilf_pkg::CH_OPEN) begin
        brace_seen_nxt   = 1'b1;
        run_open_nxt     = 1'b1;
        digits_valid_nxt = 1'b0;
        size_acc_nxt     = '0;
      end else if (fold_digit) begin
        if (run_open_r) begin
          size_acc_nxt = (acc_x10 > {4'd0, ilf_pkg::SIZE_SAT}) ? ilf_pkg::SIZE_SAT
                                                               : acc_x10[AW-1:0];
          digits_valid_nxt = 1'b1;
        end
      end else begin
        run_open_nxt     = 1'b0;
        digits_valid_nxt = 1'b0;
      end
      recent1_nxt = recent0_r;
      recent0_nxt = b;
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_literal_r   <= 1'b0;
      bytes_left_r   <= '0;
      recent0_r      <= '0;
      recent1_r      <= '0;
      brace_seen_r   <= 1'b0;
      digits_valid_r <= 1'b0;
      run_open_r     <= 1'b0;
      size_acc_r     <= '0;
    end else if (in_fire) begin
      in_literal_r   <= in_literal_nxt;
      bytes_left_r   <= bytes_left_nxt;
      recent0_r      <= recent0_nxt;
      recent1_r      <= recent1_nxt;
      brace_seen_r   <= brace_seen_nxt;
      digits_valid_r <= digits_valid_nxt;
      run_open_r     <= run_open_nxt;
      size_acc_r     <= size_acc_nxt;
    end
  end

  // Result register and skid stage
  ilf_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_ch.valid),
    .s_ready (skid_ready),
    .s_data  (res),
    .m_valid (out_ch.valid),
    .m_ready (out_ch.ready),
    .m_data  (out_data)
  );

  assign out_ch.out_byte       = out_data.out_byte;
  assign out_ch.is_payload     = out_data.is_payload;
  assign out_ch.literal_begins = out_data.literal_begins;
  assign out_ch.literal_length = out_data.literal_length;
  assign out_ch.response_done  = out_data.response_done;
  assign out_ch.error_code     = out_data.error_code;

endmodule
